// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checkers of this project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/cle_pkg.sv -----
// ----------------------------------------------------------------------------
// Console line editor package
// Key codes, result codes and the default ring depth.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cle_pkg;

	localparam int DEF_LINE_DEPTH = 128;

	localparam logic [7:0] KEY_NUL    = 8'h00;
	localparam logic [7:0] KEY_CTRL_P = 8'h10;
	localparam logic [7:0] KEY_CTRL_U = 8'h15;
	localparam logic [7:0] KEY_CTRL_X = 8'h18;
	localparam logic [7:0] KEY_CTRL_C = 8'h03;
	localparam logic [7:0] KEY_CTRL_H = 8'h08;
	localparam logic [7:0] KEY_CTRL_D = 8'h04;
	localparam logic [7:0] KEY_DEL    = 8'h7F;
	localparam logic [7:0] KEY_CR     = 8'h0D;
	localparam logic [7:0] KEY_LF     = 8'h0A;

	localparam logic CMD_RX  = 1'b0;
	localparam logic CMD_POP = 1'b1;

	typedef enum logic [1:0] {
		EV_NONE  = 2'd0,
		EV_PLIST = 2'd1,
		EV_PANIC = 2'd2,
		EV_INTR  = 2'd3
	} event_t;

	typedef enum logic [2:0] {
		RS_NONE  = 3'd0,
		RS_DATA  = 3'd1,
		RS_LINE  = 3'd2,
		RS_EOF   = 3'd3,
		RS_EMPTY = 3'd4
	} rd_status_t;

endpackage

// ----- design/cle_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cle_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- design/console_line_editor_top.sv -----
// ----------------------------------------------------------------------------
// Console line editor
// An accepted item is held in the input register and its result is then
// written to the output register, where it can be taken. Throughput: one item
// per cycle while the output is not stalled, set by the index update and the
// registered read of the line store.
// Reset clears the read, commit and edit indices; the store is not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module console_line_editor_top import cle_pkg::*; #(
	parameter int LINE_DEPTH = DEF_LINE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       cmd,
	input  logic [7:0] rx_char,
	input  logic       first_of_read,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       echo_valid,
	output logic [7:0] echo_char,
	output logic [7:0] erase_count,
	output logic [1:0] event_res,
	output logic       wake_reader,
	output logic [7:0] read_char,
	output logic [2:0] read_status
);

	// Indices run modulo twice the depth so that a full ring and an empty ring
	// look different; the store slot is the index modulo the depth.
	localparam int SPAN   = 2 * LINE_DEPTH;
	localparam int IDX_W  = $clog2(SPAN);
	localparam int ADDR_W = $clog2(LINE_DEPTH);

	localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(SPAN - 1);
	localparam logic [IDX_W-1:0] IDX_DEPTH = IDX_W'(LINE_DEPTH);
	localparam logic [IDX_W-1:0] IDX_ALMOST = IDX_W'(LINE_DEPTH - 1);
	localparam logic [IDX_W:0]   SPAN_X    = (IDX_W + 1)'(SPAN);

	function automatic logic [IDX_W-1:0] idx_next(input logic [IDX_W-1:0] x);
		return (x == IDX_LAST) ? '0 : x + 1'b1;
	endfunction

	function automatic logic [IDX_W-1:0] idx_prev(input logic [IDX_W-1:0] x);
		return (x == '0) ? IDX_LAST : x - 1'b1;
	endfunction

	function automatic logic [IDX_W-1:0] idx_dist(input logic [IDX_W-1:0] hi,
		input logic [IDX_W-1:0] lo);
		logic [IDX_W:0] diff;
		diff = {1'b0, hi} - {1'b0, lo};
		if (hi < lo) begin
			diff = diff + SPAN_X;
		end
		return diff[IDX_W-1:0];
	endfunction

	function automatic logic [ADDR_W-1:0] idx_slot(input logic [IDX_W-1:0] x);
		logic [IDX_W-1:0] s;
		s = (x >= IDX_DEPTH) ? x - IDX_DEPTH : x;
		return s[ADDR_W-1:0];
	endfunction

	// Input register. The item held here is worked on combinationally and its
	// result lands in the output register.
	logic       valid_s1;
	logic       cmd_s1;
	logic [7:0] char_s1;
	logic       first_s1;

	// Ring indices.
	logic [IDX_W-1:0] read_q;
	logic [IDX_W-1:0] commit_q;
	logic [IDX_W-1:0] edit_q;

	// Output register.
	logic       out_valid_q;
	logic       echo_valid_q;
	logic [7:0] echo_char_q;
	logic [7:0] erase_q;
	event_t     event_q;
	logic       wake_q;
	logic [7:0] rchar_q;
	rd_status_t rstat_q;

	// Write-to-read forwarding for the line store.
	logic       hit_q;
	logic [7:0] hit_data_q;

	logic             advance;
	logic             update;
	logic [IDX_W-1:0] read_d;
	logic [IDX_W-1:0] commit_d;
	logic [IDX_W-1:0] edit_d;
	logic             store_en;
	logic [7:0]       store_char;
	logic [IDX_W-1:0] dist_er;
	logic [IDX_W-1:0] dist_ec;
	logic [7:0]       head_char;
	logic             ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [ADDR_W-1:0] ram_raddr;
	logic [7:0]       ram_rdata;

	logic       r_echo_valid;
	logic [7:0] r_echo_char;
	logic [7:0] r_erase;
	event_t     r_event;
	logic       r_wake;
	logic [7:0] r_rchar;
	rd_status_t r_rstat;

	// The output register can take a new result when it is empty or being read.
	assign advance  = !out_valid_q || !out_stall;
	assign update   = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	assign dist_er = idx_dist(edit_q, read_q);
	assign dist_ec = idx_dist(edit_q, commit_q);

	// The byte at the head of the committed data, with a write from the
	// previous cycle to the same slot taking precedence over the old contents.
	assign head_char = hit_q ? hit_data_q : ram_rdata;

	always_comb begin
		read_d       = read_q;
		commit_d     = commit_q;
		edit_d       = edit_q;
		store_en     = 1'b0;
		store_char   = (char_s1 == KEY_CR) ? KEY_LF : char_s1;
		r_echo_valid = 1'b0;
		r_echo_char  = '0;
		r_erase      = '0;
		r_event      = EV_NONE;
		r_wake       = 1'b0;
		r_rchar      = '0;
		r_rstat      = RS_NONE;
		if (cmd_s1 == CMD_RX) begin
			priority if (char_s1 == KEY_CTRL_P) begin
				r_event = EV_PLIST;
			end else if (char_s1 == KEY_CTRL_X) begin
				r_event = EV_PANIC;
			end else if (char_s1 == KEY_CTRL_C) begin
				r_event = EV_INTR;
			end else if (char_s1 == KEY_CTRL_U) begin
				// Kill line: every uncommitted byte goes, nothing lies past commit.
				edit_d  = commit_q;
				r_erase = (32'(dist_ec) > 32'd255) ? 8'd255 : 8'(dist_ec);
			end else if (char_s1 == KEY_CTRL_H || char_s1 == KEY_DEL) begin
				if (edit_q != commit_q) begin
					edit_d  = idx_prev(edit_q);
					r_erase = 8'd1;
				end
			end else if (char_s1 != KEY_NUL && dist_er < IDX_DEPTH) begin
				store_en     = 1'b1;
				edit_d       = idx_next(edit_q);
				r_echo_valid = 1'b1;
				r_echo_char  = store_char;
				// A line ends on newline, end-of-file or when this byte fills the ring.
				if (store_char == KEY_LF || store_char == KEY_CTRL_D ||
					dist_er == IDX_ALMOST) begin
					commit_d = idx_next(edit_q);
					r_wake   = 1'b1;
				end
			end else begin
				// A zero byte, or a byte that finds the ring full, is dropped.
				r_event = EV_NONE;
			end
		end else begin
			priority if (read_q == commit_q) begin
				r_rstat = RS_EMPTY;
			end else if (head_char == KEY_CTRL_D) begin
				// The end-of-file mark is consumed only by the first pop of a read.
				if (first_s1) begin
					read_d = idx_next(read_q);
				end
				r_rstat = RS_EOF;
			end else begin
				read_d  = idx_next(read_q);
				r_rchar = head_char;
				r_rstat = (head_char == KEY_LF) ? RS_LINE : RS_DATA;
			end
		end
	end

	assign ram_we    = update && store_en;
	assign ram_waddr = idx_slot(edit_q);
	// Look up the slot that will be the head of the ring in the next cycle.
	assign ram_raddr = idx_slot(update ? read_d : read_q);

	cle_ram #(
		.WIDTH(8),
		.DEPTH(LINE_DEPTH)
	) u_line_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(store_char),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			read_q      <= '0;
			commit_q    <= '0;
			edit_q      <= '0;
			out_valid_q <= 1'b0;
			hit_q       <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (update) begin
				read_q   <= read_d;
				commit_q <= commit_d;
				edit_q   <= edit_d;
			end
			if (advance) begin
				out_valid_q <= valid_s1;
			end
			hit_q <= ram_we && (ram_waddr == ram_raddr);
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			cmd_s1   <= cmd;
			char_s1  <= rx_char;
			first_s1 <= first_of_read;
		end
		hit_data_q <= store_char;
		if (update) begin
			echo_valid_q <= r_echo_valid;
			echo_char_q  <= r_echo_char;
			erase_q      <= r_erase;
			event_q      <= r_event;
			wake_q       <= r_wake;
			rchar_q      <= r_rchar;
			rstat_q      <= r_rstat;
		end
	end

	assign out_valid   = out_valid_q;
	assign echo_valid  = echo_valid_q;
	assign echo_char   = echo_char_q;
	assign erase_count = erase_q;
	assign event_res   = event_q;
	assign wake_reader = wake_q;
	assign read_char   = rchar_q;
	assign read_status = rstat_q;

endmodule

// ----- design/cle_checker.sv -----
// ----------------------------------------------------------------------------
// Console line editor checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cle_checker import cle_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic       echo_valid,
	input logic [7:0] echo_char,
	input logic [7:0] erase_count,
	input logic [1:0] event_res,
	input logic       wake_reader,
	input logic [7:0] read_char,
	input logic [2:0] read_status
);

	// A stalled result holds its item.
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(read_status) && $stable(read_char) && $stable(echo_char), "stalled result changed")

	// A read result carries nothing of the receive side.
	`ASSERT_SAME(a_read_alone, clk, arst_n, out_valid && read_status != RS_NONE, !echo_valid && erase_count == 8'd0 && event_res == EV_NONE && !wake_reader, "read result mixed with edit fields")

	// A popped byte is shown only with a data status.
	`ASSERT_SAME(a_rchar_status, clk, arst_n, out_valid && read_char != 8'd0, read_status == RS_DATA || read_status == RS_LINE, "read byte without data status")

	// A line is committed only by a byte that was stored and echoed.
	`ASSERT_SAME(a_wake_echo, clk, arst_n, out_valid && wake_reader, echo_valid && echo_char != KEY_CR, "wake without stored byte")

	// An echoed byte neither erases nor raises an event.
	`ASSERT_SAME(a_echo_alone, clk, arst_n, out_valid && echo_valid, erase_count == 8'd0 && event_res == EV_NONE && echo_char != 8'd0, "echo mixed with edit action")

endmodule

bind console_line_editor_top cle_checker u_cle_checker (.*);
